[hdl/positional_list_engine_macros.svh]
// Assertion macros shared by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ple_pkg.sv]
// Types and constants shared by the positional list engine and its cells.
package ple_pkg;

    localparam int DEPTH       = 8;
    localparam int MAX_RESULTS = 8;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FND_W = $clog2(MAX_RESULTS + 1);

    typedef logic [7:0]         t_pos;
    typedef logic signed [31:0] t_value;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_DELETE = 3'd1,
        FUNC_GET    = 3'd2,
        FUNC_CHANGE = 3'd3,
        FUNC_LOCATE = 3'd4,
        FUNC_LENGTH = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_POS   = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_WRITE,
        CELL_COMPARE,
        CELL_SHIFT_MATCH
    } t_cell_op;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        t_cell_op op;
        t_pos     pos_idx;
        t_value   key;
    } t_cell_ctl;

endpackage

[hdl/ple_cell.sv]
// One list cell: holds an entry and a match flag, and trades both with its neighbors.
module ple_cell
    import ple_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_pos      i_index,
    input  logic      i_live,
    input  t_value    i_prev_value,
    input  t_value    i_next_value,
    input  logic      i_next_match,
    output t_value    o_value,
    output logic      o_hit,
    output logic      o_match
);

    t_value r_value;
    t_value n_value;
    logic   r_match;
    logic   n_match;
    logic   w_at_pos;
    logic   w_above;

    assign w_at_pos = (i_index == i_ctl.pos_idx);
    assign w_above  = (i_index > i_ctl.pos_idx);
    assign o_hit    = i_live && (r_value == i_ctl.key);

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (w_above) begin
                    n_value = i_prev_value;
                end else if (w_at_pos) begin
                    n_value = i_ctl.key;
                end
            end
            CELL_DELETE: begin
                if (w_above || w_at_pos) begin
                    n_value = i_next_value;
                end
            end
            CELL_WRITE: begin
                if (w_at_pos) begin
                    n_value = i_ctl.key;
                end
            end
            CELL_COMPARE: begin
                n_match = o_hit;
            end
            CELL_SHIFT_MATCH: begin
                n_match = i_next_match;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

[hdl/positional_list_engine.sv]
// A result is registered at the edge that accepts its input beat, except a locate that finds a match.
// Throughput: insert, delete, get, change and length take one beat per cycle while the output is not stalled.
// Locate compares all cells at once, then match flags move one cell per cycle toward
// the head while no match at the head is waiting on a stalled output.
// Reset clears the entry count, the controller state and the output valid;
// entry contents stay undefined until written.
`include "positional_list_engine_macros.svh"

module positional_list_engine
    import ple_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [3:0]         o_match_position,
    output logic [3:0]         o_list_length,
    output logic               o_last
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_scan_idx;
    logic [IDX_W-1:0] n_scan_idx;
    logic [FND_W-1:0] r_found;
    logic [FND_W-1:0] n_found;
    t_value           r_key;

    logic             r_o_valid;
    t_status          r_o_status;
    t_value           r_o_read_value;
    logic [3:0]       r_o_match_position;
    logic [3:0]       r_o_list_length;
    logic             r_o_last;

    t_cell_ctl        w_ctl;
    t_value           w_value [DEPTH];
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_match;

    t_func            w_func;
    logic             w_out_free;
    logic             w_accept;
    logic             w_has_room;
    logic             w_ins_pos_ok;
    logic             w_rw_pos_ok;
    logic             w_rest_any;
    logic [CNT_W-1:0] w_scan_pos;
    t_pos             w_pos_idx;

    logic             e_emit;
    t_status          e_status;
    t_value           e_read_value;
    logic [3:0]       e_match_position;
    logic             e_last;

    assign w_func       = t_func'(i_func);
    assign w_out_free   = !r_o_valid || !i_stall;
    assign o_stall      = !((r_state == ST_IDLE) && w_out_free);
    assign w_accept     = i_valid && !o_stall;
    assign w_pos_idx    = i_position - 8'd1;
    assign w_has_room   = (r_count < CNT_W'(DEPTH));
    assign w_ins_pos_ok = (i_position != 8'd0) && (9'(i_position) <= 9'(r_count) + 9'd1);
    assign w_rw_pos_ok  = (i_position != 8'd0) && (9'(i_position) <= 9'(r_count));
    assign w_rest_any   = |(w_match >> 1);
    assign w_scan_pos   = CNT_W'(r_scan_idx) + CNT_W'(1);

    // The chain: each cell sees its left and right neighbors' entries and
    // the right neighbor's match flag.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_value w_prev;
        t_value w_next;
        logic   w_next_match;

        if (k == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_value[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_next       = '0;
            assign w_next_match = 1'b0;
        end else begin : g_inner
            assign w_next       = w_value[k+1];
            assign w_next_match = w_match[k+1];
        end

        ple_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_index      (8'(k)),
            .i_live       (CNT_W'(k) < r_count),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .i_next_match (w_next_match),
            .o_value      (w_value[k]),
            .o_hit        (w_hit[k]),
            .o_match      (w_match[k])
        );
    end

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_scan_idx       = r_scan_idx;
        n_found          = r_found;
        w_ctl.op         = CELL_HOLD;
        w_ctl.pos_idx    = w_pos_idx;
        w_ctl.key        = i_value;
        e_emit           = 1'b0;
        e_status         = STAT_OK;
        e_read_value     = '0;
        e_match_position = '0;
        e_last           = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    e_emit = 1'b1;
                    unique case (w_func)
                        FUNC_INSERT: begin
                            if (!w_has_room) begin
                                e_status = STAT_FULL;
                            end else if (!w_ins_pos_ok) begin
                                e_status = STAT_BAD_POS;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_DELETE: begin
                            if (!w_rw_pos_ok) begin
                                e_status = STAT_BAD_POS;
                            end else begin
                                w_ctl.op = CELL_DELETE;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        FUNC_GET: begin
                            if (!w_rw_pos_ok) begin
                                e_status = STAT_BAD_POS;
                            end else begin
                                e_read_value = w_value[w_pos_idx[IDX_W-1:0]];
                            end
                        end
                        FUNC_CHANGE: begin
                            if (!w_rw_pos_ok) begin
                                e_status = STAT_BAD_POS;
                            end else begin
                                w_ctl.op = CELL_WRITE;
                            end
                        end
                        FUNC_LOCATE: begin
                            w_ctl.op = CELL_COMPARE;
                            if (!(|w_hit)) begin
                                e_status = STAT_NOT_FOUND;
                            end else begin
                                e_emit     = 1'b0;
                                n_state    = ST_SCAN;
                                n_scan_idx = '0;
                                n_found    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctl.key = r_key;
                if (!w_match[0] || w_out_free) begin
                    w_ctl.op   = CELL_SHIFT_MATCH;
                    n_scan_idx = r_scan_idx + IDX_W'(1);
                end
                if (w_match[0] && w_out_free) begin
                    e_emit           = 1'b1;
                    e_read_value     = r_key;
                    e_match_position = 4'(w_scan_pos);
                    e_last           = !w_rest_any || (r_found == FND_W'(MAX_RESULTS - 1));
                    n_found          = r_found + FND_W'(1);
                    if (e_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_scan_idx <= '0;
            r_found    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_scan_idx <= n_scan_idx;
            r_found    <= n_found;
            if (w_accept && (w_func == FUNC_LOCATE)) begin
                r_key <= i_value;
            end
            if (e_emit) begin
                r_o_valid          <= 1'b1;
                r_o_status         <= e_status;
                r_o_read_value     <= e_read_value;
                r_o_match_position <= e_match_position;
                r_o_list_length    <= 4'(n_count);
                r_o_last           <= e_last;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_read_value     = r_o_read_value;
    assign o_match_position = r_o_match_position;
    assign o_list_length    = r_o_list_length;
    assign o_last           = r_o_last;

    `PLE_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "entry count exceeds depth")
    `PLE_ASSERT_NOW(a_scan_has_match, i_clk, i_rst_n, r_state == ST_SCAN, |w_match, "scan running with no match flag left")
    `PLE_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_accept && (w_func == FUNC_INSERT) && w_has_room && w_ins_pos_ok, r_count == $past(r_count) + CNT_W'(1), "insert did not grow the list")
    `PLE_ASSERT_NOW(a_found_cap, i_clk, i_rst_n, r_state == ST_SCAN, r_found < FND_W'(MAX_RESULTS), "too many locate results")

endmodule
